>>> rtl/canvas_command_vertex_generator_top_assert.svh
// assertion macros for the canvas command vertex generator
// no dependencies, included by the top level
`ifndef CANVAS_COMMAND_VERTEX_GENERATOR_TOP_ASSERT_SVH
`define CANVAS_COMMAND_VERTEX_GENERATOR_TOP_ASSERT_SVH

// same-cycle implication
`define CVG_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CVG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/cvg_pkg.sv
// shared types, constants and helpers for the canvas command vertex generator
// no dependencies
package cvg_pkg;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int QUEUE_DEPTH     = 4;
  localparam int IN_DATA_W       = 144;
  localparam int OUT_DATA_W      = 80;
  localparam int OP_W            = 4;

  localparam logic [15:0] ONE_Q88   = 16'd256;
  localparam logic [8:0]  GA_ONE    = 9'd256;
  localparam logic [7:0]  OVF_MAX   = 8'd255;
  localparam logic [7:0]  ALPHA_MAX = 8'd255;
  localparam logic [2:0]  VTX_LAST  = 3'd5;
  localparam logic [23:0] Q_MAX     = 24'h7FFFFF;
  localparam logic [23:0] Q_MIN     = 24'h800000;

  typedef enum logic [OP_W-1:0] {
    OP_FILL_COLOR   = 4'd0,
    OP_STROKE_COLOR = 4'd1,
    OP_LINE_WIDTH   = 4'd2,
    OP_GLOBAL_ALPHA = 4'd3,
    OP_FILL_RECT    = 4'd4,
    OP_STROKE_RECT  = 4'd5,
    OP_CLEAR_RECT   = 4'd6,
    OP_SAVE         = 4'd7,
    OP_RESTORE      = 4'd8,
    OP_TRANSLATE    = 4'd9,
    OP_NOOP         = 4'd10
  } op_t;

  typedef enum logic [1:0] {
    SIDE_TOP    = 2'd0,
    SIDE_RIGHT  = 2'd1,
    SIDE_BOTTOM = 2'd2,
    SIDE_LEFT   = 2'd3
  } side_t;

  // drawing context, also the stack entry
  typedef struct packed {
    logic [31:0] fill;
    logic [31:0] stroke;
    logic [15:0] lw;
    logic [8:0]  ga;
    logic [23:0] ox;
    logic [23:0] oy;
  } ctx_t;

  localparam ctx_t CTX_RESET = '{
    fill: 32'h000000FF, stroke: 32'h000000FF, lw: ONE_Q88, ga: GA_ONE,
    ox: 24'd0, oy: 24'd0
  };

  // drawing command after the corner add
  typedef struct packed {
    logic        stroke;
    logic [23:0] x;
    logic [23:0] y;
    logic [23:0] rw;
    logic [23:0] rh;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [8:0]  ga;
    logic [14:0] half;
  } draw_t;

  // job handed to the vertex emitter
  typedef struct packed {
    logic        stroke;
    logic [23:0] x;
    logic [23:0] y;
    logic [23:0] x2;
    logic [23:0] y2;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [14:0] half;
    logic        nx;
    logic        ny;
    logic        gx;
    logic        gy;
  } job_t;

  function automatic int addr_w(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

  function automatic logic [23:0] sat_add24(input logic [23:0] a, input logic [23:0] b);
    logic [24:0] s;
    s = {a[23], a} + {b[23], b};
    if (s[24] != s[23]) begin
      return s[24] ? Q_MIN : Q_MAX;
    end
    return s[23:0];
  endfunction

endpackage

>>> rtl/canvas_command_vertex_generator_top.sv
// canvas command vertex generator top: front end, job queue, vertex emitter
// depends on cvg_pkg, cvg_front, cvg_queue, cvg_back and the assertion header
// path: rectangle command -> front-end snapshot register -> job queue -> output register
// throughput: one vertex word per cycle from the emitter when m_tready allows; one command
// per cycle while the four-job queue has room and no restore stack ram read is pending
// reset: synchronous, restores default style and empties the queue; stack ram is not cleared
`include "canvas_command_vertex_generator_top_assert.svh"

module canvas_command_vertex_generator_top import cvg_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // pos_x, pos_y, rect_w, rect_h, color_red, color_green, color_blue, color_alpha,
  // scalar_value
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // operation
  input  logic [OP_W-1:0]       s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // vertex_x, vertex_y, out_red, out_green, out_blue, out_alpha
  output logic [OUT_DATA_W-1:0] m_tdata,
  // last_vertex
  output logic                  m_tlast
);

  logic push, q_full, head_valid, pop;
  job_t push_job, head_job;

  cvg_front #(
    .StackDepth (STACK_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .push     (push),
    .push_job (push_job),
    .q_full   (q_full)
  );

  cvg_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop)
  );

  cvg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

  `CVG_ASSERT_IMPLIES(a_no_push_full, clk, rst, push, !q_full, "job pushed into full queue")
  `CVG_ASSERT_IMPLIES(a_pop_valid, clk, rst, pop, head_valid, "job popped from empty queue")
  `CVG_ASSERT_NEXT(a_pop_last, clk, rst, pop, m_tvalid && m_tlast, "job retired without last word")

endmodule

>>> rtl/cvg_ram.sv
// generic single write port ram with registered read
// no dependencies
module cvg_ram import cvg_pkg::*; #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [addr_w(Depth)-1:0]   wr_addr,
  input  logic [Width-1:0]           wr_data,
  input  logic                       rd_en,
  input  logic [addr_w(Depth)-1:0]   rd_addr,
  output logic [Width-1:0]           rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/cvg_front.sv
// command front end: context registers, save stack, corner add, job build
// depends on cvg_pkg and cvg_ram
module cvg_front import cvg_pkg::*; #(
  parameter int StackDepth = STACK_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_DATA_W-1:0] s_tdata,
  input  logic [OP_W-1:0]      s_tuser,
  output logic                 push,
  output job_t                 push_job,
  input  logic                 q_full
);

  localparam int LevelW = $clog2(StackDepth + 1);
  localparam int AddrW  = addr_w(StackDepth);

  logic [OP_W-1:0]  op;
  logic [23:0]      pos_x, pos_y, rect_w, rect_h;
  logic [7:0]       color_red, color_green, color_blue, color_alpha;
  logic [15:0]      scalar_value;

  ctx_t             ctx;
  ctx_t             rd_ctx;
  logic [LevelW-1:0] level;
  logic [LevelW-1:0] level_dec;
  logic [7:0]       ovf;
  logic             rest_pend;
  logic             s1_valid;
  draw_t            s1;

  logic             acc, is_draw, save_ok, wr_en, rd_en;
  logic [23:0]      cx, cy, x2, y2;
  logic [15:0]      lw_eff;
  logic [16:0]      prod;

  assign op           = s_tuser;
  assign pos_x        = s_tdata[23:0];
  assign pos_y        = s_tdata[47:24];
  assign rect_w       = s_tdata[71:48];
  assign rect_h       = s_tdata[95:72];
  assign color_red    = s_tdata[103:96];
  assign color_green  = s_tdata[111:104];
  assign color_blue   = s_tdata[119:112];
  assign color_alpha  = s_tdata[127:120];
  assign scalar_value = s_tdata[143:128];

  always_comb begin
    s_tready  = !rest_pend && (!s1_valid || !q_full);
    acc       = s_tvalid && s_tready;
    is_draw   = (op == OP_FILL_RECT) || (op == OP_STROKE_RECT) || (op == OP_CLEAR_RECT);
    save_ok   = level != LevelW'(StackDepth);
    wr_en     = acc && (op == OP_SAVE) && save_ok;
    rd_en     = acc && (op == OP_RESTORE) && (ovf == 8'd0) && (level != '0);
    level_dec = level - LevelW'(1);
    cx        = sat_add24(pos_x, ctx.ox);
    cy        = sat_add24(pos_y, ctx.oy);
    lw_eff    = (ctx.lw < ONE_Q88) ? ONE_Q88 : ctx.lw;
  end

  cvg_ram #(
    .Width ($bits(ctx_t)),
    .Depth (StackDepth)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (level[AddrW-1:0]),
    .wr_data (ctx),
    .rd_en   (rd_en),
    .rd_addr (level_dec[AddrW-1:0]),
    .rd_data (rd_ctx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ctx       <= CTX_RESET;
      level     <= '0;
      ovf       <= '0;
      rest_pend <= 1'b0;
      s1_valid  <= 1'b0;
    end else begin
      rest_pend <= rd_en;
      s1_valid  <= (acc && is_draw) || (s1_valid && q_full);
      if (rest_pend) begin
        ctx <= rd_ctx;
      end
      if (acc) begin
        case (op)
          OP_FILL_COLOR: begin
            ctx.fill <= {color_red, color_green, color_blue, color_alpha};
          end
          OP_STROKE_COLOR: begin
            ctx.stroke <= {color_red, color_green, color_blue, color_alpha};
          end
          OP_LINE_WIDTH: begin
            ctx.lw <= scalar_value;
          end
          OP_GLOBAL_ALPHA: begin
            ctx.ga <= (scalar_value > 16'(GA_ONE)) ? GA_ONE : scalar_value[8:0];
          end
          OP_SAVE: begin
            if (save_ok) begin
              level <= level + LevelW'(1);
            end else if (ovf != OVF_MAX) begin
              ovf <= ovf + 8'd1;
            end
          end
          OP_RESTORE: begin
            if (ovf != 8'd0) begin
              ovf <= ovf - 8'd1;
            end else if (level != '0) begin
              level <= level_dec;
            end
          end
          OP_TRANSLATE: begin
            ctx.ox <= sat_add24(ctx.ox, pos_x);
            ctx.oy <= sat_add24(ctx.oy, pos_y);
          end
          default: begin
          end
        endcase
      end
    end
  end

  // snapshot of style at accept time
  always_ff @(posedge clk) begin
    if (acc && is_draw) begin
      s1.stroke <= (op == OP_STROKE_RECT);
      s1.x      <= cx;
      s1.y      <= cy;
      s1.rw     <= rect_w;
      s1.rh     <= rect_h;
      s1.half   <= lw_eff[15:1];
      case (op)
        OP_FILL_RECT: begin
          {s1.red, s1.green, s1.blue, s1.alpha} <= ctx.fill;
          s1.ga <= ctx.ga;
        end
        OP_STROKE_RECT: begin
          {s1.red, s1.green, s1.blue, s1.alpha} <= ctx.stroke;
          s1.ga <= ctx.ga;
        end
        default: begin
          // clear is opaque black, unscaled
          {s1.red, s1.green, s1.blue} <= '0;
          s1.alpha <= ALPHA_MAX;
          s1.ga    <= GA_ONE;
        end
      endcase
    end
  end

  always_comb begin
    x2   = sat_add24(s1.x, s1.rw);
    y2   = sat_add24(s1.y, s1.rh);
    prod = 17'(s1.alpha) * 17'(s1.ga);
    push_job.stroke = s1.stroke;
    push_job.x      = s1.x;
    push_job.y      = s1.y;
    push_job.x2     = x2;
    push_job.y2     = y2;
    push_job.red    = s1.red;
    push_job.green  = s1.green;
    push_job.blue   = s1.blue;
    push_job.alpha  = prod[15:8];
    push_job.half   = s1.half;
    push_job.nx     = x2 != s1.x;
    push_job.ny     = y2 != s1.y;
    push_job.gx     = $signed(x2) > $signed(s1.x);
    push_job.gy     = $signed(y2) > $signed(s1.y);
    // a stroke with all four sides empty emits nothing
    push = s1_valid && !q_full && (!s1.stroke || push_job.nx || push_job.ny);
  end

endmodule

>>> rtl/cvg_queue.sv
// short job queue between the front end and the vertex emitter
// depends on cvg_pkg
module cvg_queue import cvg_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  output logic head_valid,
  output job_t head_job,
  input  logic pop
);

  localparam int PtrW = $clog2(QUEUE_DEPTH);

  job_t            slots [QUEUE_DEPTH];
  logic [PtrW-1:0] wptr, rptr;
  logic [PtrW:0]   count;

  assign full       = count == (PtrW + 1)'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_job   = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + PtrW'(1);
      end
      if (pop) begin
        rptr <= rptr + PtrW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (PtrW + 1)'(1);
        2'b01:   count <= count - (PtrW + 1)'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_job;
    end
  end

endmodule

>>> rtl/cvg_back.sv
// vertex emitter: walks quad or stroke sides, one vertex per cycle while m_tready allows
// depends on cvg_pkg
module cvg_back import cvg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  head_valid,
  input  job_t                  head_job,
  output logic                  pop,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tlast
);

  logic [2:0]  vidx;
  logic [1:0]  side;
  logic        fresh;

  logic        adv, emit, last_v, use_p2, minus, xfar, yfar, neg;
  logic [1:0]  side_cur, last_side, step;
  logic [23:0] off, off_x, off_y, vx, vy;

  always_comb begin
    adv       = !m_tvalid || m_tready;
    emit      = head_valid && adv;
    side_cur  = fresh ? ((head_job.stroke && !head_job.nx) ? SIDE_RIGHT : SIDE_TOP) : side;
    last_side = head_job.ny ? SIDE_LEFT : SIDE_BOTTOM;
    step      = (head_job.nx && head_job.ny) ? 2'd1 : 2'd2;
    last_v    = (vidx == VTX_LAST) && (!head_job.stroke || side_cur == last_side);
    pop       = emit && last_v;
    use_p2    = (vidx == 3'd2) || (vidx == 3'd4) || (vidx == 3'd5);
    minus     = (vidx == 3'd1) || (vidx == 3'd2) || (vidx == 3'd4);
    if (!head_job.stroke) begin
      xfar = minus;
      yfar = use_p2;
    end else begin
      case (side_cur)
        SIDE_TOP: begin
          xfar = use_p2;
          yfar = 1'b0;
        end
        SIDE_RIGHT: begin
          xfar = 1'b1;
          yfar = use_p2;
        end
        SIDE_BOTTOM: begin
          xfar = !use_p2;
          yfar = 1'b1;
        end
        default: begin
          xfar = 1'b0;
          yfar = !use_p2;
        end
      endcase
    end
    // normal sign per side, flipped on the minus vertices
    neg   = (side_cur[0] ? (head_job.gy ^ side_cur[1]) : (head_job.gx ^ ~side_cur[1])) ^ minus;
    off   = neg ? -{9'd0, head_job.half} : {9'd0, head_job.half};
    off_x = (head_job.stroke && side_cur[0])  ? off : '0;
    off_y = (head_job.stroke && !side_cur[0]) ? off : '0;
    vx    = sat_add24(xfar ? head_job.x2 : head_job.x, off_x);
    vy    = sat_add24(yfar ? head_job.y2 : head_job.y, off_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vidx     <= '0;
      side     <= SIDE_TOP;
      fresh    <= 1'b1;
      m_tvalid <= 1'b0;
    end else begin
      if (adv) begin
        m_tvalid <= head_valid;
      end
      if (emit) begin
        if (last_v) begin
          vidx  <= '0;
          fresh <= 1'b1;
        end else if (vidx == VTX_LAST) begin
          vidx  <= '0;
          side  <= side_cur + step;
          fresh <= 1'b0;
        end else begin
          vidx  <= vidx + 3'd1;
          side  <= side_cur;
          fresh <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {head_job.alpha, head_job.blue, head_job.green, head_job.red, vy, vx};
      m_tlast <= last_v;
    end
  end

endmodule

>>> sim/canvas_command_vertex_generator_top_tb.sv
// self-checking testbench for canvas_command_vertex_generator_top
// depends on cvg_pkg and the rtl; sends command words, predicts every vertex word
// and compares the vertex stream against that prediction or, for typed rows, the row's vertex
module canvas_command_vertex_generator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cvg_pkg::*;

  localparam int DEPTH = STACK_DEPTH_DEF;
  localparam int OVF_SAT = 255;
  localparam int EXTRA_SAVES = 4;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 20;
  localparam int STALL_LIMIT = 5000;
  localparam int MAX_REPORTS = 10;
  localparam int WIDTH_ONE = 256;
  localparam logic [8:0] GALPHA_ONE = 9'd256;
  localparam logic [3:0] OP_CODE_TOP = 4'hF;
  localparam longint COORD_MAX = 8388607;
  localparam longint COORD_MIN = -8388608;
  localparam logic [31:0] OPAQUE_BLACK = 32'h000000FF;

  typedef struct {
    logic [3:0]         op;
    logic signed [23:0] px, py, rw, rh;
    logic [31:0]        rgba;
    logic [15:0]        scalar;
  } command_t;

  typedef struct {
    logic [23:0] x, y;
    logic [7:0]  r, g, b, a;
    logic        last;
  } vertex_t;

  typedef struct {
    logic [31:0]        fill, stroke;
    logic [15:0]        width;
    logic [8:0]         galpha;
    logic signed [23:0] ox, oy;
  } style_frame_t;

  // directed rows: typed rows carry n_vtx copies of one known vertex
  typedef struct packed {
    logic [3:0]  op;
    logic [23:0] px, py, rw, rh;
    logic [31:0] rgba;
    logic [15:0] scalar;
    logic        typed;
    logic [4:0]  n_vtx;
    logic [23:0] vx, vy;
    logic [31:0] vrgba;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [25] = '{
    '{OP_CLEAR_RECT, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 32'h00000000,
      16'h0000, 1'b1, 5'd6, 24'h000000, 24'h000000, 32'h000000FF},
    '{OP_FILL_RECT, 24'h7FFFFF, 24'h800000, 24'h000000, 24'h000000, 32'h00000000,
      16'h0000, 1'b1, 5'd6, 24'h7FFFFF, 24'h800000, 32'h000000FF},
    '{OP_STROKE_RECT, 24'h800000, 24'h7FFFFF, 24'h000000, 24'h000000, 32'h00000000,
      16'h0000, 1'b1, 5'd0, 24'h000000, 24'h000000, 32'h00000000},
    '{OP_RESTORE, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 32'h00000000,
      16'h0000, 1'b1, 5'd0, 24'h000000, 24'h000000, 32'h00000000},
    '{OP_GLOBAL_ALPHA, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 32'h00000000,
      16'hFFFF, 1'b0, 5'd0, 24'h000000, 24'h000000, 32'h00000000},
    '{OP_FILL_COLOR, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 32'h80FF01FF,
      16'h0000, 1'b0, 5'd0, 24'h000000, 24'h000000, 32'h00000000},
    '{OP_FILL_RECT, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 32'h00000000,
      16'h0000, 1'b1, 5'd6, 24'h000000, 24'h000000, 32'h80FF01FF},
    '{OP_STROKE_COLOR, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 32'h12345678,
      16'h0000, 1'b0, 5'd0, 24'h000000, 24'h000000, 32'h00000000},
    '{OP_LINE_WIDTH, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 32'h00000000,
      16'h0000, 1'b0, 5'd0, 24'h000000, 24'h000000, 32'h00000000},
    '{OP_STROKE_RECT, 24'hFFFF00, 24'h000200, 24'h000400, 24'hFFFD00, 32'h00000000,
      16'h0000, 1'b0, 5'd0, 24'h000000, 24'h000000, 32'h00000000},
    '{OP_GLOBAL_ALPHA, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 32'h00000000,
      16'h0080, 1'b0, 5'd0, 24'h000000, 24'h000000, 32'h00000000},
    '{OP_FILL_RECT, 24'h7FFF00, 24'h7FFF00, 24'h7FFFFF, 24'h7FFFFF, 32'h00000000,
      16'h0000, 1'b0, 5'd0, 24'h000000, 24'h000000, 32'h00000000},
    '{OP_STROKE_RECT, 24'h000100, 24'h000100, 24'h000000, 24'h000A00, 32'h00000000,
      16'h0000, 1'b0, 5'd0, 24'h000000, 24'h000000, 32'h00000000},
    '{OP_STROKE_RECT, 24'h000100, 24'h000100, 24'h000A00, 24'h000000, 32'h00000000,
      16'h0000, 1'b0, 5'd0, 24'h000000, 24'h000000, 32'h00000000},
    '{OP_SAVE, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 32'h00000000,
      16'h0000, 1'b0, 5'd0, 24'h000000, 24'h000000, 32'h00000000},
    '{OP_TRANSLATE, 24'h7FFFFF, 24'h800000, 24'h000000, 24'h000000, 32'h00000000,
      16'h0000, 1'b0, 5'd0, 24'h000000, 24'h000000, 32'h00000000},
    '{OP_LINE_WIDTH, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 32'h00000000,
      16'hFFFF, 1'b0, 5'd0, 24'h000000, 24'h000000, 32'h00000000},
    '{OP_STROKE_RECT, 24'hFFFF00, 24'h000100, 24'h000800, 24'h000800, 32'h00000000,
      16'h0000, 1'b0, 5'd0, 24'h000000, 24'h000000, 32'h00000000},
    '{OP_CLEAR_RECT, 24'h000000, 24'h000000, 24'h800000, 24'h7FFFFF, 32'h00000000,
      16'h0000, 1'b0, 5'd0, 24'h000000, 24'h000000, 32'h00000000},
    '{OP_TRANSLATE, 24'h800000, 24'h800000, 24'h000000, 24'h000000, 32'h00000000,
      16'h0000, 1'b0, 5'd0, 24'h000000, 24'h000000, 32'h00000000},
    '{OP_RESTORE, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 32'h00000000,
      16'h0000, 1'b0, 5'd0, 24'h000000, 24'h000000, 32'h00000000},
    '{OP_FILL_COLOR, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 32'h00000000,
      16'h0000, 1'b0, 5'd0, 24'h000000, 24'h000000, 32'h00000000},
    '{OP_FILL_RECT, 24'h000100, 24'h000100, 24'hFFFE00, 24'hFFFD00, 32'h00000000,
      16'h0000, 1'b0, 5'd0, 24'h000000, 24'h000000, 32'h00000000},
    '{OP_CODE_TOP, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 32'hFFFFFFFF,
      16'hFFFF, 1'b1, 5'd0, 24'h000000, 24'h000000, 32'h00000000},
    '{OP_NOOP, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 32'h00000000,
      16'h0000, 1'b1, 5'd0, 24'h000000, 24'h000000, 32'h00000000}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [OP_W-1:0]       s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;

  // predicted drawing state
  logic [31:0]        cur_fill = OPAQUE_BLACK;
  logic [31:0]        cur_stroke = OPAQUE_BLACK;
  logic [15:0]        cur_width = 16'(WIDTH_ONE);
  logic [8:0]         cur_galpha = GALPHA_ONE;
  logic signed [23:0] org_x = '0;
  logic signed [23:0] org_y = '0;
  style_frame_t       saved [DEPTH];
  int                 save_level = 0;
  int                 lost_saves = 0;

  vertex_t cmd_vertices [$];
  vertex_t pending_vertices [$];
  int      mismatches = 0;
  int      idle_cycles = 0;
  bit      tx_idle_en = 1'b1;
  bit      rx_idle_en = 1'b1;
  bit      hold_req = 1'b0;

  canvas_command_vertex_generator_top uut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast
  );

  always #6 clk = ~clk;

  function automatic logic signed [23:0] clamp24(input longint v);
    if (v > COORD_MAX) return 24'sh7FFFFF;
    if (v < COORD_MIN) return 24'sh800000;
    return v[23:0];
  endfunction

  function automatic longint sign_of(input longint v);
    return (v > 0) ? 64'sd1 : ((v < 0) ? -64'sd1 : 64'sd0);
  endfunction

  function automatic void emit_vertex(input longint vx, input longint vy,
                                      input logic [31:0] rgba);
    vertex_t v;
    v.x = clamp24(vx);
    v.y = clamp24(vy);
    {v.r, v.g, v.b, v.a} = rgba;
    v.last = 1'b0;
    cmd_vertices = {cmd_vertices, v};
  endfunction

  function automatic void emit_quad(input longint x, input longint y, input longint x2,
                                    input longint y2, input logic [31:0] rgba);
    emit_vertex(x, y, rgba);
    emit_vertex(x2, y, rgba);
    emit_vertex(x2, y2, rgba);
    emit_vertex(x, y, rgba);
    emit_vertex(x2, y2, rgba);
    emit_vertex(x, y2, rgba);
  endfunction

  function automatic void emit_side(input longint x1, input longint y1, input longint x2,
                                    input longint y2, input longint half,
                                    input logic [31:0] rgba);
    longint nx, ny;
    if (x1 == x2 && y1 == y2) return;
    nx = -sign_of(y2 - y1) * half;
    ny = sign_of(x2 - x1) * half;
    emit_vertex(x1 + nx, y1 + ny, rgba);
    emit_vertex(x1 - nx, y1 - ny, rgba);
    emit_vertex(x2 - nx, y2 - ny, rgba);
    emit_vertex(x1 + nx, y1 + ny, rgba);
    emit_vertex(x2 - nx, y2 - ny, rgba);
    emit_vertex(x2 + nx, y2 + ny, rgba);
  endfunction

  // updates the drawing state and leaves the command's vertices in cmd_vertices
  function automatic void predict_vertices(input command_t c);
    longint x, y, x2, y2, half;
    logic [7:0] fa, sa;
    logic [31:0] sc;
    cmd_vertices.delete();
    x = clamp24(longint'(c.px) + longint'(org_x));
    y = clamp24(longint'(c.py) + longint'(org_y));
    x2 = clamp24(x + longint'(c.rw));
    y2 = clamp24(y + longint'(c.rh));
    fa = 8'((int'(cur_fill[7:0]) * int'(cur_galpha)) >> 8);
    sa = 8'((int'(cur_stroke[7:0]) * int'(cur_galpha)) >> 8);
    half = ((int'(cur_width) < WIDTH_ONE) ? longint'(WIDTH_ONE) : longint'(cur_width)) >> 1;
    sc = {cur_stroke[31:8], sa};
    case (c.op)
      OP_FILL_COLOR: cur_fill = c.rgba;
      OP_STROKE_COLOR: cur_stroke = c.rgba;
      OP_LINE_WIDTH: cur_width = c.scalar;
      OP_GLOBAL_ALPHA: cur_galpha = (c.scalar > GALPHA_ONE) ? GALPHA_ONE : c.scalar[8:0];
      OP_FILL_RECT: emit_quad(x, y, x2, y2, {cur_fill[31:8], fa});
      OP_STROKE_RECT: begin
        emit_side(x, y, x2, y, half, sc);
        emit_side(x2, y, x2, y2, half, sc);
        emit_side(x2, y2, x, y2, half, sc);
        emit_side(x, y2, x, y, half, sc);
      end
      OP_CLEAR_RECT: emit_quad(x, y, x2, y2, OPAQUE_BLACK);
      OP_SAVE: begin
        if (save_level < DEPTH) begin
          saved[save_level] = '{cur_fill, cur_stroke, cur_width, cur_galpha, org_x, org_y};
          save_level++;
        end else if (lost_saves < OVF_SAT) begin
          lost_saves++;
        end
      end
      OP_RESTORE: begin
        if (lost_saves > 0) begin
          lost_saves--;
        end else if (save_level > 0) begin
          save_level--;
          cur_fill = saved[save_level].fill;
          cur_stroke = saved[save_level].stroke;
          cur_width = saved[save_level].width;
          cur_galpha = saved[save_level].galpha;
          org_x = saved[save_level].ox;
          org_y = saved[save_level].oy;
        end
      end
      OP_TRANSLATE: begin
        org_x = clamp24(longint'(org_x) + longint'(c.px));
        org_y = clamp24(longint'(org_y) + longint'(c.py));
      end
      default: ;
    endcase
    if (cmd_vertices.size() > 0) cmd_vertices[cmd_vertices.size() - 1].last = 1'b1;
  endfunction

  // mostly small coordinates, sometimes zero, sometimes any 24-bit value
  function automatic logic signed [23:0] rand_q(input int span);
    case ($urandom_range(0, 7))
      0: return 24'($urandom);
      1: return 24'sd0;
      default: return 24'($urandom_range(0, 2 * span) - span);
    endcase
  endfunction

  function automatic command_t random_command();
    command_t c;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 30) c.op = OP_FILL_RECT;
    else if (sel < 50) c.op = OP_STROKE_RECT;
    else if (sel < 58) c.op = OP_CLEAR_RECT;
    else if (sel < 64) c.op = OP_FILL_COLOR;
    else if (sel < 70) c.op = OP_STROKE_COLOR;
    else if (sel < 75) c.op = OP_LINE_WIDTH;
    else if (sel < 80) c.op = OP_GLOBAL_ALPHA;
    else if (sel < 86) c.op = OP_SAVE;
    else if (sel < 92) c.op = OP_RESTORE;
    else if (sel < 97) c.op = OP_TRANSLATE;
    else c.op = 4'($urandom_range(OP_NOOP, OP_CODE_TOP));
    c.px = rand_q(16'h2000);
    c.py = rand_q(16'h2000);
    c.rw = rand_q(16'h1000);
    c.rh = rand_q(16'h1000);
    c.rgba = $urandom;
    c.scalar = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 16'h300));
    return c;
  endfunction

  task automatic issue(input command_t c, input bit typed = 1'b0, input int n = 0,
                       input logic [23:0] tx = '0, input logic [23:0] ty = '0,
                       input logic [31:0] trgba = '0);
    vertex_t v;
    s_tvalid <= 1'b1;
    s_tuser <= c.op;
    s_tdata <= {c.scalar, c.rgba[7:0], c.rgba[15:8], c.rgba[23:16], c.rgba[31:24],
                c.rh, c.rw, c.py, c.px};
    do @(posedge clk); while (!s_tready);
    predict_vertices(c);
    if (typed) begin
      for (int k = 0; k < n; k++) begin
        v.x = tx;
        v.y = ty;
        {v.r, v.g, v.b, v.a} = trgba;
        v.last = (k == n - 1);
        pending_vertices = {pending_vertices, v};
      end
    end else begin
      pending_vertices = {pending_vertices, cmd_vertices};
    end
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  initial begin
    command_t c;
    dir_row_t row;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIR_ROWS[i]) begin
      row = DIR_ROWS[i];
      c.op = row.op;
      c.px = row.px;
      c.py = row.py;
      c.rw = row.rw;
      c.rh = row.rh;
      c.rgba = row.rgba;
      c.scalar = row.scalar;
      issue(c, row.typed, int'(row.n_vtx), row.vx, row.vy, row.vrgba);
    end
    wait_for_results();

    // output held off for a long stretch while commands keep arriving
    tx_idle_en = 1'b0;
    hold_req = 1'b1;
    for (int i = 0; i < 30; i++) issue(random_command());

    for (int i = 0; i < 60; i++) begin
      if (i % 25 == 0) begin
        tx_idle_en = $urandom_range(0, 1);
        rx_idle_en = $urandom_range(0, 1);
      end
      issue(random_command());
    end
    wait_for_results();

    // fill the stack, overflow it, then unwind past empty
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    for (int i = 0; i < DEPTH; i++) begin
      c = random_command();
      case ($urandom_range(0, 4))
        0: c.op = OP_FILL_COLOR;
        1: c.op = OP_STROKE_COLOR;
        2: c.op = OP_LINE_WIDTH;
        3: c.op = OP_GLOBAL_ALPHA;
        default: c.op = OP_TRANSLATE;
      endcase
      issue(c);
      c = random_command();
      c.op = OP_SAVE;
      issue(c);
    end
    for (int i = 0; i < EXTRA_SAVES; i++) begin
      c = random_command();
      c.op = OP_SAVE;
      issue(c);
    end
    for (int i = 0; i < EXTRA_SAVES; i++) begin
      c = random_command();
      c.op = OP_RESTORE;
      issue(c);
    end
    for (int i = 0; i < DEPTH + 2; i++) begin
      c = random_command();
      c.op = OP_RESTORE;
      issue(c);
      c = random_command();
      c.op = $urandom_range(0, 1) ? OP_FILL_RECT : OP_STROKE_RECT;
      issue(c);
    end

    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    for (int i = 0; i < 40; i++) issue(random_command());
    wait_for_results();

    if (mismatches == 0 && pending_vertices.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    do @(posedge clk); while (rst);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_word
    vertex_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.x = m_tdata[23:0];
      got.y = m_tdata[47:24];
      got.r = m_tdata[55:48];
      got.g = m_tdata[63:56];
      got.b = m_tdata[71:64];
      got.a = m_tdata[79:72];
      got.last = m_tlast;
      if (pending_vertices.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("unexpected vertex word: x=%h y=%h rgba=%h%h%h%h last=%b",
                   got.x, got.y, got.r, got.g, got.b, got.a, got.last);
        mismatches++;
      end else begin
        want = pending_vertices.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.r !== want.r || got.g !== want.g ||
            got.b !== want.b || got.a !== want.a || got.last !== want.last) begin
          if (mismatches < MAX_REPORTS)
            $display("vertex mismatch: exp x=%h y=%h rgba=%h%h%h%h last=%b,",
                     want.x, want.y, want.r, want.g, want.b, want.a, want.last,
                     " got x=%h y=%h rgba=%h%h%h%h last=%b",
                     got.x, got.y, got.r, got.g, got.b, got.a, got.last);
          mismatches++;
        end
      end
    end
  end

  // no word moving on either side for too long means the block is stuck
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/cvg_pkg.sv
rtl/cvg_ram.sv
rtl/cvg_front.sv
rtl/cvg_queue.sv
rtl/cvg_back.sv
rtl/canvas_command_vertex_generator_top.sv
sim/canvas_command_vertex_generator_top_tb.sv
